// ===== design/fbfl_pkg.sv =====
package fbfl_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;

    localparam logic [CNT_W-1:0] EMPTY_MARK = CNT_W'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0] RESET_COUNT = CNT_W'(MAX_BLOCKS);

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NO_BLOCK  = 2'd1,
        ST_BAD_INDEX = 2'd2
    } status_t;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } opcode_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [CNT_W-1:0] data;
    } link_wr_t;

    // Link of an entry in a freshly built chain: the next index, or the empty
    // mark for the last block of the pool and everything above it.
    function automatic logic [CNT_W-1:0] chain_link(input logic [CNT_W-1:0] count,
                                                    input logic [IDX_W-1:0] addr);
        logic [CNT_W:0] nxt;
        begin
            nxt = {2'b00, addr} + (CNT_W+1)'(1);
            if (nxt < {1'b0, count})
                chain_link = nxt[CNT_W-1:0];
            else
                chain_link = EMPTY_MARK;
        end
    endfunction

endpackage

// ===== design/fixed_block_free_list_allocator.sv =====
// Free-list allocator for a pool of block_count equal blocks (1 to 256). An
// item with opcode 0 pops the head of the free list and returns its index; an
// item with opcode 1 pushes release_index back as the new head. Every item gives
// one result in the cycle after it is accepted, carrying status, the granted
// index and the number of free blocks left. One item is accepted in every cycle
// unless the result is stalled: the head and the link of the head are held in
// registers, and the link memory is read ahead at the address that will be the
// head's successor, with a bypass for a write to that same entry. Writing
// block_count rebuilds the chain in index order at once through per-entry valid
// bits, so there is no clearing pass; write it only while no item is in flight.
module fixed_block_free_list_allocator
    import fbfl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] release_index
    input  logic [0:0]  s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] granted_index, [16:8] free_blocks, rest zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] link1_reg, link1_next;
    logic [CNT_W-1:0] free_reg, free_next;
    logic             out_valid_reg;
    status_t          status_reg, status_next;
    logic [IDX_W-1:0] granted_reg, granted_next;
    logic [CNT_W-1:0] rd_link;
    logic [CNT_W-1:0] cfg_value;
    logic             rebuild;
    logic             accept;
    link_wr_t         wr;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        cfg_value = cfg_wdata;
        if (cfg_value == '0)
            cfg_value = CNT_W'(1);
        else if (cfg_value > RESET_COUNT)
            cfg_value = RESET_COUNT;
    end

    always_comb
    begin
        count_next   = count_reg;
        head_next    = head_reg;
        link1_next   = link1_reg;
        free_next    = free_reg;
        status_next  = ST_DONE;
        granted_next = '0;
        rebuild      = 1'b0;
        wr.en        = 1'b0;
        wr.addr      = s_tdata[IDX_W-1:0];
        wr.data      = head_reg;
        if (cfg_wen)
        begin
            rebuild    = 1'b1;
            count_next = cfg_value;
            head_next  = '0;
            link1_next = chain_link(cfg_value, '0);
            free_next  = cfg_value;
        end
        else if (accept)
        begin
            case (opcode_t'(s_tuser[0]))
                OP_ALLOC:
                begin
                    if (head_reg == EMPTY_MARK)
                        status_next = ST_NO_BLOCK;
                    else
                    begin
                        granted_next = head_reg[IDX_W-1:0];
                        head_next    = link1_reg;
                        link1_next   = rd_link;
                        if (free_reg != '0)
                            free_next = free_reg - CNT_W'(1);
                    end
                end
                OP_RELEASE:
                begin
                    if ({1'b0, s_tdata[IDX_W-1:0]} >= count_reg)
                        status_next = ST_BAD_INDEX;
                    else
                    begin
                        wr.en      = 1'b1;
                        head_next  = {1'b0, s_tdata[IDX_W-1:0]};
                        link1_next = head_reg;
                        if (free_reg < count_reg)
                            free_next = free_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end
    end

    fbfl_link_mem u_link_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (link1_next[IDX_W-1:0]),
        .wr      (wr),
        .rebuild (rebuild),
        .count   (count_next),
        .rd_link (rd_link)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= RESET_COUNT;
            head_reg      <= '0;
            link1_reg     <= chain_link(RESET_COUNT, '0);
            free_reg      <= RESET_COUNT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            head_reg  <= head_next;
            link1_reg <= link1_next;
            free_reg  <= free_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
        end
    end

    // The free count is reported as it stands right after the item.
    logic [CNT_W-1:0] free_out_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
            free_out_reg <= free_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {7'b0, free_out_reg, granted_reg};

endmodule

// ===== design/fbfl_link_mem.sv =====
module fbfl_link_mem
    import fbfl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] rd_addr,
    input  link_wr_t         wr,
    input  logic             rebuild,
    input  logic [CNT_W-1:0] count,
    output logic [CNT_W-1:0] rd_link
);

    logic [CNT_W-1:0]      mem [MAX_BLOCKS];
    logic [CNT_W-1:0]      mem_q;
    logic [MAX_BLOCKS-1:0] valid_reg;
    logic                  fwd_reg;
    logic                  use_dflt_reg;
    logic [CNT_W-1:0]      dflt_reg;
    logic [CNT_W-1:0]      wdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
        mem_q     <= mem[rd_addr];
        wdata_reg <= wr.data;
    end

    // Entries not written since the last rebuild read as the in-order chain.
    // A write to the address being read this cycle is bypassed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            fwd_reg      <= 1'b0;
            use_dflt_reg <= 1'b1;
            dflt_reg     <= chain_link(RESET_COUNT, IDX_W'(1));
        end
        else
        begin
            if (rebuild)
                valid_reg <= '0;
            else if (wr.en)
                valid_reg[wr.addr] <= 1'b1;
            fwd_reg      <= !rebuild && wr.en && (wr.addr == rd_addr);
            use_dflt_reg <= rebuild || !valid_reg[rd_addr];
            dflt_reg     <= chain_link(count, rd_addr);
        end
    end

    assign rd_link = fwd_reg ? wdata_reg : (use_dflt_reg ? dflt_reg : mem_q);

endmodule
